// ===== hdl/tcl_pkg.sv =====
package tcl_pkg;

  // Field widths
  localparam int COL_W   = 7;
  localparam int ROW_W   = 6;
  localparam int CHAR_W  = 8;
  localparam int CMD_W   = 2;
  localparam int KIND_W  = 2;
  localparam int PC_W    = 5;
  localparam int CNT_W   = 4;
  localparam int CFG_IDX_W = 1;

  // Stream word widths (fields packed from bit 0, padded to bytes)
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // Most results one input word may cause
  localparam logic [CNT_W:0] MAX_RESULTS = 5'd8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_COL   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_ROW = 1'b1;

  localparam logic [COL_W-1:0] WRAP_COL_RST   = 7'd78;
  localparam logic [ROW_W-1:0] BOTTOM_ROW_RST = 6'd24;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CHAR   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FINISH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SET    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_GLYPH  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SCROLL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CURSOR = 2'd2;

  // Special characters
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // Microcode operations
  typedef enum logic [2:0] {
    OP_NOP,
    OP_FETCH,
    OP_TABDEC,
    OP_PLACE,
    OP_NEWLINE,
    OP_SET,
    OP_DONE
  } op_t;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_CMD_SET,
    C_CMD_FIN,
    C_CMD_NONE,
    C_CH_LF,
    C_CH_CR,
    C_CH_NOT_TAB,
    C_TAB_END,
    C_NOT_WRAPPED,
    C_COL_ZERO
  } cond_t;

  // One control word
  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic            g_space;
    logic [PC_W-1:0] target;
  } ctrl_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic cmd_set;
    logic cmd_fin;
    logic cmd_none;
    logic ch_lf;
    logic ch_cr;
    logic ch_not_tab;
    logic tab_end;
    logic not_wrapped;
    logic col_zero;
  } flags_t;

  // One result
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] glyph;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } res_t;

endpackage

// ===== hdl/text_cursor_layout_engine.sv =====
// Text console cursor engine.
// Input stream (in_*): one command word per handshake. in_tuser = cmd;
// in_tdata carries char_code, set_col, set_row. Commands: character,
// finish line, set cursor; code 3 only reports the cursor.
// Output stream (out_*): 1 to 8 result words per command, the last one
// flagged by out_tlast. out_tuser = kind (glyph, scroll, cursor update).
// Config port (cfg_*): index 0 wrap column, index 1 bottom row; write only
// while the engine is idle. cfg_ready is always high.
// Timing: a microcode sequencer steps one control word per cycle unless
// stalled. The input is accepted in the fetch step. Results pass through
// a one-word hold stage and an output register, so a new word is pushed
// while the previous one waits.
// Reset: cursor goes to 0,0, wrap column to 78, bottom row to 24, output
// empty. A stalled receiver freezes the sequencer at its next emit step
// that finds the hold stage full, or at its done step.
module text_cursor_layout_engine #(
  parameter int TAB_STOP = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [tcl_pkg::IN_DATA_W-1:0]        in_tdata,   // char_code, set_col, set_row
  input  logic [tcl_pkg::CMD_W-1:0]            in_tuser,   // cmd
  // output stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [tcl_pkg::OUT_DATA_W-1:0]       out_tdata,  // glyph, col, row
  output logic [tcl_pkg::KIND_W-1:0]           out_tuser,  // kind
  output logic                                 out_tlast,
  // configuration
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tcl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tcl_pkg::COL_W-1:0]            cfg_data
);

  localparam int TW = $clog2(TAB_STOP + 1);
  localparam int NCOL = 2 ** tcl_pkg::COL_W;

  typedef logic [NCOL-1:0][TW-1:0] rem_tbl_t;

  // Column modulo tab stop, built at elaboration
  function automatic rem_tbl_t build_rem();
    rem_tbl_t t;
    for (int i = 0; i < NCOL; i++) begin
      t[i] = TW'(i % TAB_STOP);
    end
    return t;
  endfunction

  localparam rem_tbl_t REM_TBL = build_rem();

  tcl_pkg::ctrl_t  ctrl;
  tcl_pkg::flags_t flags;
  logic            stall;

  // config registers
  logic [tcl_pkg::COL_W-1:0] wrap_col_r;
  logic [tcl_pkg::ROW_W-1:0] bottom_row_r;

  // cursor and latched command
  logic [tcl_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [tcl_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [tcl_pkg::CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [tcl_pkg::CHAR_W-1:0] ch_r, ch_nxt;
  logic [tcl_pkg::COL_W-1:0]  scol_r, scol_nxt;
  logic [tcl_pkg::ROW_W-1:0]  srow_r, srow_nxt;
  logic [TW-1:0]              tabn_r, tabn_nxt;
  logic [tcl_pkg::CNT_W-1:0]  k_r, k_nxt;

  // hold stage and output register
  tcl_pkg::res_t pend_r, pend_nxt;
  logic          pend_v_r, pend_v_nxt;
  tcl_pkg::res_t out_r, out_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          can_move;
  logic          wrapped;
  logic          at_bottom;
  logic [tcl_pkg::CNT_W:0] k_need;
  logic          emit;
  tcl_pkg::res_t emit_res;

  tcl_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .stall (stall),
    .ctrl  (ctrl)
  );

  assign cfg_ready = 1'b1;
  assign in_tready = (ctrl.op == tcl_pkg::OP_FETCH);

  assign can_move  = !out_valid_r || out_tready;
  assign wrapped   = (col_r >= wrap_col_r);
  assign at_bottom = (row_r >= bottom_row_r);
  assign k_need    = {1'b0, k_r} + ((wrapped && at_bottom) ? 5'd2 : 5'd1);

  // Status for the sequencer
  always_comb begin
    flags.in_valid    = in_tvalid;
    flags.cmd_set     = (cmd_r == tcl_pkg::CMD_SET);
    flags.cmd_fin     = (cmd_r == tcl_pkg::CMD_FINISH);
    flags.cmd_none    = (cmd_r == tcl_pkg::CMD_NONE);
    flags.ch_lf       = (ch_r == tcl_pkg::CH_LF);
    flags.ch_cr       = (ch_r == tcl_pkg::CH_CR);
    flags.ch_not_tab  = (ch_r != tcl_pkg::CH_TAB);
    flags.tab_end     = (tabn_r == '0) || (k_need > tcl_pkg::MAX_RESULTS);
    flags.not_wrapped = !wrapped;
    flags.col_zero    = (col_r == '0);
  end

  // Hold the step while a push has nowhere to go
  always_comb begin
    unique case (ctrl.op)
      tcl_pkg::OP_PLACE:   stall = pend_v_r && !can_move;
      tcl_pkg::OP_NEWLINE: stall = at_bottom && pend_v_r && !can_move;
      tcl_pkg::OP_DONE:    stall = !can_move;
      default:             stall = 1'b0;
    endcase
  end

  // Datapath
  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    cmd_nxt       = cmd_r;
    ch_nxt        = ch_r;
    scol_nxt      = scol_r;
    srow_nxt      = srow_r;
    tabn_nxt      = tabn_r;
    k_nxt         = k_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    out_nxt       = out_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    emit          = 1'b0;
    emit_res      = '0;

    if (!stall) begin
      unique case (ctrl.op)
        tcl_pkg::OP_FETCH: begin
          if (in_tvalid) begin
            cmd_nxt    = in_tuser;
            ch_nxt     = in_tdata[7:0];
            scol_nxt   = in_tdata[14:8];
            srow_nxt   = in_tdata[20:15];
            tabn_nxt   = TW'(TAB_STOP) - REM_TBL[col_r];
            k_nxt      = '0;
            pend_v_nxt = 1'b0;
          end
        end
        tcl_pkg::OP_TABDEC: begin
          if (!flags.tab_end) begin
            tabn_nxt = tabn_r - TW'(1);
          end
        end
        tcl_pkg::OP_PLACE: begin
          emit           = 1'b1;
          emit_res.kind  = tcl_pkg::KIND_GLYPH;
          emit_res.glyph = ctrl.g_space ? tcl_pkg::CH_SPACE : ch_r;
          emit_res.col   = col_r;
          emit_res.row   = row_r;
          if (!wrapped) begin
            col_nxt = col_r + 7'd1;
          end
        end
        tcl_pkg::OP_NEWLINE: begin
          col_nxt = '0;
          if (!at_bottom) begin
            row_nxt = row_r + 6'd1;
          end else begin
            emit          = 1'b1;
            emit_res.kind = tcl_pkg::KIND_SCROLL;
            emit_res.row  = row_r;
          end
        end
        tcl_pkg::OP_SET: begin
          col_nxt = scol_r;
          row_nxt = srow_r;
        end
        tcl_pkg::OP_DONE: begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (pend_v_r) begin
            out_nxt = pend_r;
          end else begin
            out_nxt.kind  = tcl_pkg::KIND_CURSOR;
            out_nxt.glyph = '0;
            out_nxt.col   = col_r;
            out_nxt.row   = row_r;
          end
          pend_v_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end

    // A new result pushes the held one out as a non-final word
    if (emit) begin
      k_nxt      = k_r + 4'd1;
      pend_nxt   = emit_res;
      pend_v_nxt = 1'b1;
      if (pend_v_r) begin
        out_nxt       = pend_r;
        out_last_nxt  = 1'b0;
        out_valid_nxt = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_col_r   <= tcl_pkg::WRAP_COL_RST;
      bottom_row_r <= tcl_pkg::BOTTOM_ROW_RST;
      col_r        <= '0;
      row_r        <= '0;
      pend_v_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index == tcl_pkg::CFG_WRAP_COL) begin
        wrap_col_r <= cfg_data;
      end
      if (cfg_valid && cfg_index == tcl_pkg::CFG_BOTTOM_ROW) begin
        bottom_row_r <= cfg_data[tcl_pkg::ROW_W-1:0];
      end
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    ch_r       <= ch_nxt;
    scol_r     <= scol_nxt;
    srow_r     <= srow_nxt;
    tabn_r     <= tabn_nxt;
    k_r        <= k_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r.row, out_r.col, out_r.glyph};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_last_r;

endmodule

// ===== hdl/tcl_seq.sv =====
module tcl_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  tcl_pkg::flags_t   flags,
  input  logic              stall,
  output tcl_pkg::ctrl_t    ctrl
);

  // Program entry points
  localparam logic [tcl_pkg::PC_W-1:0] A_FETCH = 5'd0;
  localparam logic [tcl_pkg::PC_W-1:0] A_TAB   = 5'd7;
  localparam logic [tcl_pkg::PC_W-1:0] A_GLYPH = 5'd10;
  localparam logic [tcl_pkg::PC_W-1:0] A_SET   = 5'd13;
  localparam logic [tcl_pkg::PC_W-1:0] A_FIN   = 5'd14;
  localparam logic [tcl_pkg::PC_W-1:0] A_NL    = 5'd15;
  localparam logic [tcl_pkg::PC_W-1:0] A_DONE  = 5'd16;

  logic [tcl_pkg::PC_W-1:0] pc_r;
  logic [tcl_pkg::PC_W-1:0] pc_nxt;
  logic                     taken;

  function automatic tcl_pkg::ctrl_t mk(input tcl_pkg::op_t op, input tcl_pkg::cond_t cnd,
                                        input logic gs, input logic [tcl_pkg::PC_W-1:0] tgt);
    tcl_pkg::ctrl_t w;
    w.op      = op;
    w.cond    = cnd;
    w.g_space = gs;
    w.target  = tgt;
    return w;
  endfunction

  // Control store
  function automatic tcl_pkg::ctrl_t ucode(input logic [tcl_pkg::PC_W-1:0] a);
    tcl_pkg::ctrl_t w;
    unique case (a)
      5'd0:  w = mk(tcl_pkg::OP_FETCH,   tcl_pkg::C_NO_INPUT,    1'b0, A_FETCH);
      5'd1:  w = mk(tcl_pkg::OP_NOP,     tcl_pkg::C_CMD_SET,     1'b0, A_SET);
      5'd2:  w = mk(tcl_pkg::OP_NOP,     tcl_pkg::C_CMD_FIN,     1'b0, A_FIN);
      5'd3:  w = mk(tcl_pkg::OP_NOP,     tcl_pkg::C_CMD_NONE,    1'b0, A_DONE);
      5'd4:  w = mk(tcl_pkg::OP_NOP,     tcl_pkg::C_CH_LF,       1'b0, A_NL);
      5'd5:  w = mk(tcl_pkg::OP_NOP,     tcl_pkg::C_CH_CR,       1'b0, A_DONE);
      5'd6:  w = mk(tcl_pkg::OP_NOP,     tcl_pkg::C_CH_NOT_TAB,  1'b0, A_GLYPH);
      // tab loop: check budget, place a space, new line on wrap
      5'd7:  w = mk(tcl_pkg::OP_TABDEC,  tcl_pkg::C_TAB_END,     1'b0, A_DONE);
      5'd8:  w = mk(tcl_pkg::OP_PLACE,   tcl_pkg::C_NOT_WRAPPED, 1'b1, A_TAB);
      5'd9:  w = mk(tcl_pkg::OP_NEWLINE, tcl_pkg::C_ALWAYS,      1'b0, A_TAB);
      // plain glyph
      5'd10: w = mk(tcl_pkg::OP_PLACE,   tcl_pkg::C_NOT_WRAPPED, 1'b0, A_DONE);
      5'd11: w = mk(tcl_pkg::OP_NOP,     tcl_pkg::C_ALWAYS,      1'b0, A_NL);
      5'd13: w = mk(tcl_pkg::OP_SET,     tcl_pkg::C_ALWAYS,      1'b0, A_DONE);
      5'd14: w = mk(tcl_pkg::OP_NOP,     tcl_pkg::C_COL_ZERO,    1'b0, A_DONE);
      5'd15: w = mk(tcl_pkg::OP_NEWLINE, tcl_pkg::C_NEVER,       1'b0, A_DONE);
      5'd16: w = mk(tcl_pkg::OP_DONE,    tcl_pkg::C_ALWAYS,      1'b0, A_FETCH);
      default: w = mk(tcl_pkg::OP_DONE,  tcl_pkg::C_ALWAYS,      1'b0, A_FETCH);
    endcase
    return w;
  endfunction

  assign ctrl = ucode(pc_r);

  // Condition select
  always_comb begin
    unique case (ctrl.cond)
      tcl_pkg::C_NEVER:       taken = 1'b0;
      tcl_pkg::C_ALWAYS:      taken = 1'b1;
      tcl_pkg::C_NO_INPUT:    taken = !flags.in_valid;
      tcl_pkg::C_CMD_SET:     taken = flags.cmd_set;
      tcl_pkg::C_CMD_FIN:     taken = flags.cmd_fin;
      tcl_pkg::C_CMD_NONE:    taken = flags.cmd_none;
      tcl_pkg::C_CH_LF:       taken = flags.ch_lf;
      tcl_pkg::C_CH_CR:       taken = flags.ch_cr;
      tcl_pkg::C_CH_NOT_TAB:  taken = flags.ch_not_tab;
      tcl_pkg::C_TAB_END:     taken = flags.tab_end;
      tcl_pkg::C_NOT_WRAPPED: taken = flags.not_wrapped;
      tcl_pkg::C_COL_ZERO:    taken = flags.col_zero;
      default:                taken = 1'b0;
    endcase
  end

  // Next step
  always_comb begin
    if (stall) begin
      pc_nxt = pc_r;
    end else if (taken) begin
      pc_nxt = ctrl.target;
    end else begin
      pc_nxt = pc_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= A_FETCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== hdl/tcl_chk.sv =====
module tcl_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tcl_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [tcl_pkg::KIND_W-1:0]      out_tuser,
  input logic                            out_tlast
);

  // Output empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // A stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output word changed");

  // Cursor-only report is always the final word of its command
  a_cursor_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == tcl_pkg::KIND_CURSOR |-> out_tlast)
    else $error("cursor update not final");

  // Only glyph words carry a character
  a_glyph_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != tcl_pkg::KIND_GLYPH |-> out_tdata[7:0] == 8'h00)
    else $error("non-glyph word carries a character");

endmodule

bind text_cursor_layout_engine tcl_chk u_tcl_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
